>>> design/lstk_pkg.sv
`default_nettype none

package lstk_pkg;

    // store geometry
    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // payload widths fixed by the item format
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 9;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_SEARCH,
        ST_DELIVER
    } state_t;

endpackage

`default_nettype wire

>>> design/lstk_if.sv
`default_nettype none

// command channel: one operation per transfer
interface lstk_cmd_if import lstk_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] operand_value;

    modport source (output valid, output opcode, output operand_value, input ready);
    modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

// response channel: one result per command
interface lstk_rsp_if import lstk_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] popped_value;
    logic [POS_W-1:0]        found_position;

    modport source (output valid, output status, output popped_value, output found_position,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input found_position,
                    output ready);
endinterface

`default_nettype wire

>>> design/lifo_stack_with_search.sv
// LIFO stack of signed 32-bit words with a top-down search.
// cmd channel (sink): opcode and operand_value; push, pop, search or no-op.
// rsp channel (source): status, popped_value, found_position; exactly one
// result per command, in command order.
// Commands are taken one at a time; cmd.ready is high only while the
// sequencer is idle. Sequencer states that a command passes through:
//   push, no-op, and pop or search on an empty stack: ST_DELIVER
//   pop: ST_POP_WAIT (one registered read of the store), then ST_DELIVER
//   search: ST_SEARCH until the first match or the last filled entry,
//   then ST_DELIVER; one entry of the store is read and compared per cycle.
// The sequencer returns to idle as the result is loaded into the output
// register, so a command is taken only after the result of the previous
// command has left ST_DELIVER for the output register.
// A new command may be taken while a result still waits in the output
// register; its own result is held until the receiver frees that register.
// While rsp.ready is low the result stays valid and unchanged.
// Reset (rst_n low, asynchronous) empties the stack and drops any pending
// result; the store contents are not cleared and need no clearing pass.
`default_nettype none

module lifo_stack_with_search
    import lstk_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    lstk_cmd_if.sink      cmd,
    lstk_rsp_if.source    rsp
);

    // stack store, single write port and single registered read port
    logic [VAL_W-1:0] mem [STACK_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic             wr_en;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [VAL_W-1:0]  key_reg, key_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  cmp_pos_reg, cmp_pos_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_popped_reg, res_popped_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [VAL_W-1:0]  out_popped_reg, out_popped_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;

    logic cmd_xfer;
    logic is_full;
    logic is_empty;
    logic hit;

    assign cmd_xfer = cmd.valid && cmd.ready;
    assign is_full  = (fill_reg == CNT_W'(STACK_DEPTH));
    assign is_empty = (fill_reg == '0);
    assign hit      = (rd_data_reg == key_reg);

    assign cmd.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.popped_value   = out_popped_reg;
    assign rsp.found_position = out_pos_reg;

    // store write and read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= cmd.operand_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        addr_reg       <= addr_next;
        cmp_pos_reg    <= cmp_pos_next;
        res_status_reg <= res_status_next;
        res_popped_reg <= res_popped_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_popped_reg <= out_popped_next;
        out_pos_reg    <= out_pos_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        cmp_pos_next    = cmp_pos_reg;
        res_status_next = res_status_reg;
        res_popped_next = res_popped_reg;
        res_pos_next    = res_pos_reg;
        out_status_next = out_status_reg;
        out_popped_next = out_popped_reg;
        out_pos_next    = out_pos_reg;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        wr_en           = 1'b0;

        // output register empties on a response transfer
        out_valid_next = out_valid_reg && !rsp.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    res_status_next = STATUS_OK;
                    res_popped_next = '0;
                    res_pos_next    = '0;
                    key_next        = cmd.operand_value;
                    state_next      = ST_DELIVER;
                    case (cmd.opcode)
                        OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(fill_reg - CNT_W'(1));
                                fill_next  = fill_reg - CNT_W'(1);
                                state_next = ST_POP_WAIT;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // top entry first, scan continues downwards
                                rd_en        = 1'b1;
                                rd_addr      = ADDR_W'(fill_reg - CNT_W'(1));
                                addr_next    = ADDR_W'(fill_reg - CNT_W'(2));
                                cmp_pos_next = CNT_W'(1);
                                state_next   = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            // no-op: state untouched, zero result
                        end
                    endcase
                end
            end

            ST_POP_WAIT:
            begin
                res_popped_next = rd_data_reg;
                state_next      = ST_DELIVER;
            end

            ST_SEARCH:
            begin
                // data for position cmp_pos_reg is in rd_data_reg
                if (hit)
                begin
                    res_status_next = STATUS_OK;
                    res_pos_next    = POS_W'(cmp_pos_reg);
                    state_next      = ST_DELIVER;
                end
                else if (cmp_pos_reg == fill_reg)
                begin
                    res_status_next = STATUS_NOT_FOUND;
                    res_pos_next    = '0;
                    state_next      = ST_DELIVER;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = addr_reg;
                    addr_next    = addr_reg - ADDR_W'(1);
                    cmp_pos_next = cmp_pos_reg + CNT_W'(1);
                end
            end

            ST_DELIVER:
            begin
                // hand result over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_popped_next = res_popped_reg;
                    out_pos_next    = res_pos_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_xfer && cmd.opcode == OP_PUSH && !is_full)
        |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("accepted push did not grow the stack");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (cmp_pos_reg != '0 && cmp_pos_reg <= fill_reg))
        else $error("search position outside the filled range");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER && res_status_reg == STATUS_FULL) |-> is_full)
        else $error("full status with room left");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STATUS_OK)
        |-> (out_popped_reg == '0 && out_pos_reg == '0))
        else $error("failed operation carries nonzero result fields");

endmodule

`default_nettype wire
